FILE: rtl/pisq_pkg.sv
package pisq_pkg;

  localparam int RATIO_ONE  = 65536;
  localparam int DIFF_SHIFT = 17;
  localparam int DIFF_ONE   = 131072;
  localparam int RATIO_BITS = 17;
  localparam int TOL_BITS   = 16;
  localparam int NUM_STAGES = 7;

  localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(RATIO_ONE);
  localparam logic [TOL_BITS-1:0]   TOL_RESET   = TOL_BITS'(1);

  typedef enum logic [0:0] {
    REG_SHRINK_RATIO = 1'b0,
    REG_BOX_TOL      = 1'b1
  } reg_idx_t;

  // per-stage load enables handed to the lanes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

FILE: rtl/pisq_ifs.sv
interface pisq_in_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] vertex0_x;
  logic signed [COORD_BITS-1:0] vertex0_y;
  logic signed [COORD_BITS-1:0] vertex1_x;
  logic signed [COORD_BITS-1:0] vertex1_y;
  logic signed [COORD_BITS-1:0] vertex2_x;
  logic signed [COORD_BITS-1:0] vertex2_y;
  logic signed [COORD_BITS-1:0] vertex3_x;
  logic signed [COORD_BITS-1:0] vertex3_y;

  modport source (output valid, point_x, point_y, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
                  vertex2_x, vertex2_y, vertex3_x, vertex3_y, input ready);
  modport sink (input valid, point_x, point_y, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
                vertex2_x, vertex2_y, vertex3_x, vertex3_y, output ready);
endinterface

interface pisq_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

FILE: rtl/pisq_shrink_lane.sv
// Moves one vertex pair toward each other along its edge, one coordinate.
module pisq_shrink_lane #(
  parameter int COORD_BITS = 32
) (
  input  logic                                clk,
  input  pisq_pkg::pipe_en_t                  en,
  input  logic [pisq_pkg::RATIO_BITS-1:0]     k_in,
  input  logic signed [COORD_BITS-1:0]        a_in,
  input  logic signed [COORD_BITS-1:0]        b_in,
  output logic signed [COORD_BITS-1:0]        na,
  output logic signed [COORD_BITS-1:0]        nb
);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = COORD_BITS + 20;

  logic signed [DW-1:0]                 d1;
  logic signed [COORD_BITS-1:0]         a1, a2;
  logic [pisq_pkg::RATIO_BITS-1:0]      k1;
  logic [pisq_pkg::RATIO_BITS:0]        kc1;
  logic signed [PW-1:0]                 p0, p1;

  assign kc1 = (pisq_pkg::RATIO_BITS+1)'(pisq_pkg::DIFF_ONE) - {1'b0, k1};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      d1 <= DW'(b_in) - DW'(a_in);
      a1 <= a_in;
      k1 <= k_in;
    end
    if (en.s2) begin
      p0 <= PW'(d1) * PW'($signed({2'b00, k1}));
      p1 <= PW'(d1) * PW'($signed({1'b0, kc1}));
      a2 <= a1;
    end
    // floor by arithmetic shift; result lies between a and b
    if (en.s3) begin
      na <= COORD_BITS'(PW'(a2) + (p0 >>> pisq_pkg::DIFF_SHIFT));
      nb <= COORD_BITS'(PW'(a2) + (p1 >>> pisq_pkg::DIFF_SHIFT));
    end
  end
endmodule

FILE: rtl/pisq_edge_lane.sv
// Crossing-number test of one edge (a,b) against the point, exact compare.
module pisq_edge_lane #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  pisq_pkg::pipe_en_t            en,
  input  logic signed [COORD_BITS-1:0]  ax,
  input  logic signed [COORD_BITS-1:0]  ay,
  input  logic signed [COORD_BITS-1:0]  bx,
  input  logic signed [COORD_BITS-1:0]  by,
  input  logic signed [COORD_BITS-1:0]  x,
  input  logic signed [COORD_BITS-1:0]  y,
  output logic                          tog
);
  localparam int DW = COORD_BITS + 1;
  localparam int MW = 2 * COORD_BITS + 2;

  logic                 cond4, dpos4, cond5, dpos5;
  logic signed [DW-1:0] la, lb, ra, rb;
  logic signed [MW-1:0] lp, rp;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      cond4 <= ((ay < y) && (by >= y)) || ((by < y) && (ay >= y));
      dpos4 <= by > ay;
      la    <= DW'(y) - DW'(ay);
      lb    <= DW'(bx) - DW'(ax);
      ra    <= DW'(x) - DW'(ax);
      rb    <= DW'(by) - DW'(ay);
    end
    if (en.s5) begin
      lp    <= MW'(la) * MW'(lb);
      rp    <= MW'(ra) * MW'(rb);
      cond5 <= cond4;
      dpos5 <= dpos4;
    end
  end

  assign tog = cond5 && (dpos5 ? (lp < rp) : (rp < lp));
endmodule

FILE: rtl/point_in_shrunk_quad_test.sv
// Point-in-quad test against a quadrilateral shrunk along its side edges.
// in_ch carries the query point and four vertices (signed, COORD_BITS each);
// out_ch returns one inside_res bit per input transfer, in order.
// A transfer on either channel happens on a clock edge with valid and ready
// both high. One item is taken per cycle while in_ch.ready is high; the
// pipeline has seven register stages (capture, 3 shrink stages, box/edge
// setup, edge products, compare and parity merge), and out_ch.valid is the last.
// Each pipeline stage loads when it is empty or its successor moves, so
// bubbles collapse and in_ch.ready stays high while a result waits on a
// stalled receiver, until all seven stages hold items.
// APB port: shrink_ratio at 0x0 (17 bits, above 65536 acts as 65536),
// box_tolerance at 0x4 (16 bits). Write only while the pipeline is empty.
// Reset (rst, synchronous) empties the pipeline and restores
// shrink_ratio = 65536 (no shrink) and box_tolerance = 1.
module point_in_shrunk_quad_test #(
  parameter int COORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  pisq_in_if.sink     in_ch,
  pisq_out_if.source  out_ch
);
  localparam int NS = pisq_pkg::NUM_STAGES;
  localparam int BW = COORD_BITS + 2;

  // ---------------- configuration ----------------
  logic [pisq_pkg::RATIO_BITS-1:0] shrink_ratio;
  logic [pisq_pkg::TOL_BITS-1:0]   box_tolerance;
  pisq_pkg::reg_idx_t              reg_idx;
  logic                            wr;

  assign pready  = 1'b1;
  assign reg_idx = pisq_pkg::reg_idx_t'(paddr[2]);
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      shrink_ratio  <= pisq_pkg::RATIO_RESET;
      box_tolerance <= pisq_pkg::TOL_RESET;
    end else if (wr) begin
      case (reg_idx)
        pisq_pkg::REG_SHRINK_RATIO: shrink_ratio <= pwdata[pisq_pkg::RATIO_BITS-1:0];
        pisq_pkg::REG_BOX_TOL:      box_tolerance <= pwdata[pisq_pkg::TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pisq_pkg::REG_SHRINK_RATIO: prdata = 32'(shrink_ratio);
      pisq_pkg::REG_BOX_TOL:      prdata = 32'(box_tolerance);
      default:                    prdata = '0;
    endcase
  end

  // kept fraction saturates at one; k is the moved amount in Q0.17
  logic [pisq_pkg::RATIO_BITS-1:0] k_cfg;
  assign k_cfg = (shrink_ratio > pisq_pkg::RATIO_RESET) ? '0
               : pisq_pkg::RATIO_RESET - shrink_ratio;

  // ---------------- pipeline control ----------------
  logic [NS-1:0]      v;
  logic [NS-1:0]      en;
  pisq_pkg::pipe_en_t pen;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ch.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign pen = '{s1: en[1], s2: en[2], s3: en[3], s4: en[4], s5: en[5]};
  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_ch.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // ---------------- capture stage ----------------
  logic signed [COORD_BITS-1:0]    vx0 [4];
  logic signed [COORD_BITS-1:0]    vy0 [4];
  logic signed [COORD_BITS-1:0]    pxd [5];
  logic signed [COORD_BITS-1:0]    pyd [5];
  logic [pisq_pkg::RATIO_BITS-1:0] k0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pxd[0] <= in_ch.point_x;
      pyd[0] <= in_ch.point_y;
      vx0[0] <= in_ch.vertex0_x;
      vy0[0] <= in_ch.vertex0_y;
      vx0[1] <= in_ch.vertex1_x;
      vy0[1] <= in_ch.vertex1_y;
      vx0[2] <= in_ch.vertex2_x;
      vy0[2] <= in_ch.vertex2_y;
      vx0[3] <= in_ch.vertex3_x;
      vy0[3] <= in_ch.vertex3_y;
      k0     <= k_cfg;
    end
    // point rides along to the box stage
    for (int i = 1; i < 5; i++) begin
      if (en[i]) begin
        pxd[i] <= pxd[i-1];
        pyd[i] <= pyd[i-1];
      end
    end
  end

  // ---------------- shrink lanes: pairs (0,3) and (1,2) ----------------
  logic signed [COORD_BITS-1:0] sx [4];
  logic signed [COORD_BITS-1:0] sy [4];

  pisq_shrink_lane #(.COORD_BITS(COORD_BITS)) u_shr_x03 (
    .clk(clk), .en(pen), .k_in(k0), .a_in(vx0[0]), .b_in(vx0[3]), .na(sx[0]), .nb(sx[3])
  );
  pisq_shrink_lane #(.COORD_BITS(COORD_BITS)) u_shr_y03 (
    .clk(clk), .en(pen), .k_in(k0), .a_in(vy0[0]), .b_in(vy0[3]), .na(sy[0]), .nb(sy[3])
  );
  pisq_shrink_lane #(.COORD_BITS(COORD_BITS)) u_shr_x12 (
    .clk(clk), .en(pen), .k_in(k0), .a_in(vx0[1]), .b_in(vx0[2]), .na(sx[1]), .nb(sx[2])
  );
  pisq_shrink_lane #(.COORD_BITS(COORD_BITS)) u_shr_y12 (
    .clk(clk), .en(pen), .k_in(k0), .a_in(vy0[1]), .b_in(vy0[2]), .na(sy[1]), .nb(sy[2])
  );

  // ---------------- bounding box ----------------
  logic signed [COORD_BITS-1:0] mnx01, mnx23, mxx01, mxx23, mny01, mny23, mxy01, mxy23;
  logic signed [COORD_BITS-1:0] minx4, maxx4, miny4, maxy4;
  logic signed [BW-1:0]         tol_s;
  logic                         pass5;

  assign mnx01 = (sx[0] < sx[1]) ? sx[0] : sx[1];
  assign mnx23 = (sx[2] < sx[3]) ? sx[2] : sx[3];
  assign mxx01 = (sx[0] > sx[1]) ? sx[0] : sx[1];
  assign mxx23 = (sx[2] > sx[3]) ? sx[2] : sx[3];
  assign mny01 = (sy[0] < sy[1]) ? sy[0] : sy[1];
  assign mny23 = (sy[2] < sy[3]) ? sy[2] : sy[3];
  assign mxy01 = (sy[0] > sy[1]) ? sy[0] : sy[1];
  assign mxy23 = (sy[2] > sy[3]) ? sy[2] : sy[3];
  assign tol_s = BW'($signed({1'b0, box_tolerance}));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      minx4 <= (mnx01 < mnx23) ? mnx01 : mnx23;
      maxx4 <= (mxx01 > mxx23) ? mxx01 : mxx23;
      miny4 <= (mny01 < mny23) ? mny01 : mny23;
      maxy4 <= (mxy01 > mxy23) ? mxy01 : mxy23;
    end
    if (en[5]) begin
      pass5 <= (BW'(pxd[4]) >= BW'(minx4) - tol_s) && (BW'(pxd[4]) <= BW'(maxx4) + tol_s)
            && (BW'(pyd[4]) >= BW'(miny4) - tol_s) && (BW'(pyd[4]) <= BW'(maxy4) + tol_s);
    end
  end

  // ---------------- edge lanes: v0'v1', v1'v2', v2'v3', v3'v0' ----------------
  logic [3:0] tog;

  for (genvar g = 0; g < 4; g++) begin : g_edge
    pisq_edge_lane #(.COORD_BITS(COORD_BITS)) u_edge (
      .clk(clk), .en(pen),
      .ax(sx[g]), .ay(sy[g]), .bx(sx[(g+1)%4]), .by(sy[(g+1)%4]),
      .x(pxd[3]), .y(pyd[3]),
      .tog(tog[g])
    );
  end

  // ---------------- merge: parity of crossings, gated by the box ----------------
  logic inside6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      inside6 <= pass5 && (^tog);
    end
  end

  assign out_ch.valid      = v[NS-1];
  assign out_ch.inside_res = inside6;

`ifndef SYNTH
  // a full, stalled pipeline must refuse new items
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((&v) && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pipeline full and stalled");

  // the captured shrink amount never exceeds 65536 (one half in Q0.17)
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> (k0 <= pisq_pkg::RATIO_RESET))
    else $error("shrink amount out of range");

  // reset leaves the pipeline empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (v == '0))
    else $error("pipeline not empty after reset");

  // the stage before the output stage, holding an item that cannot move, keeps it
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v[NS-2] && !en[NS-2]) |=> v[NS-2])
    else $error("item lost in stalled stage");
`endif
endmodule
